>>> rtl/cbor_pkg.sv
// Shared types, widths and helper functions for the circle/box overlap resolver.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package cbor_pkg;

    localparam int CW   = 24;
    localparam int RW   = CW - 1;
    localparam int DW   = CW + 1;
    localparam int RTW  = RW + 1;
    localparam int SQW  = 2 * RTW;
    localparam int RMW  = RTW + 2;
    localparam int NW   = RW + CW;
    localparam int QW   = CW;
    localparam int CIW  = 2;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [CIW-1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MIN_Y = 2'd1,
        CFG_MAX_X = 2'd2,
        CFG_MAX_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        coord_t          circle_x;
        coord_t          circle_y;
        logic [RW-1:0]   circle_radius;
    } item_t;

    typedef struct packed {
        coord_t  resolved_x;
        coord_t  resolved_y;
        logic    overlapped;
    } result_t;

    typedef struct packed {
        coord_t  min_x;
        coord_t  min_y;
        coord_t  max_x;
        coord_t  max_y;
    } box_t;

    typedef struct packed {
        coord_t         cx;
        coord_t         cy;
        logic [RW-1:0]  r;
        logic [RW-1:0]  ax;
        logic [RW-1:0]  ay;
        logic           neg_x;
        logic           neg_y;
        logic           in_box;
        logic           hit;
    } side_t;

    typedef struct packed {
        coord_t  cx;
        coord_t  cy;
        logic    sub_x;
        logic    sub_y;
        logic    hit;
        logic    apply;
    } dside_t;

    function automatic logic signed [DW-1:0] sext1(coord_t v);
        return {v[CW-1], v};
    endfunction

    function automatic coord_t sat_add(coord_t c, logic [QW-1:0] q, logic sub);
        logic signed [CW+1:0] s;
        logic signed [CW+1:0] e;
        begin
            e = {2'b00, q};
            s = sub ? ({{2{c[CW-1]}}, c} - e) : ({{2{c[CW-1]}}, c} + e);
            if (s > $signed({3'b000, {(CW-1){1'b1}}}))
                return {1'b0, {(CW-1){1'b1}}};
            else if (s < -$signed({3'b001, {(CW-1){1'b0}}}))
                return {1'b1, {(CW-1){1'b0}}};
            else
                return s[CW-1:0];
        end
    endfunction

endpackage

>>> rtl/cbor_geom.sv
// Front stages: closest box point, offsets, far test and squared distances.
// Depends on cbor_pkg.
`timescale 1ns / 1ps

module cbor_geom (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  cbor_pkg::item_t     item,
    input  cbor_pkg::box_t      box,
    output logic                out_valid,
    output cbor_pkg::side_t     side,
    output logic [cbor_pkg::SQW-1:0] d2
);
    import cbor_pkg::*;

    // stage 1
    logic                  v1_reg;
    logic signed [DW-1:0]  dx1_reg, dy1_reg;
    coord_t                cx1_reg, cy1_reg;
    logic [RW-1:0]         r1_reg;
    logic                  ins1_reg;

    coord_t                cx, cy, px, py, cpx, cpy;
    logic                  in_box, left, bottom, near_x;
    logic signed [DW-1:0]  ex, ey;

    always_comb
    begin
        cx     = item.circle_x;
        cy     = item.circle_y;
        in_box = (cx > box.min_x) && (cx < box.max_x) &&
                 (cy > box.min_y) && (cy < box.max_y);
        left   = $signed({cx, 1'b0}) < (sext1(box.min_x) + sext1(box.max_x));
        bottom = $signed({cy, 1'b0}) < (sext1(box.min_y) + sext1(box.max_y));
        ex     = left ? (sext1(cx) - sext1(box.min_x)) : (sext1(box.max_x) - sext1(cx));
        ey     = bottom ? (sext1(cy) - sext1(box.min_y)) : (sext1(box.max_y) - sext1(cy));
        near_x = ex < ey;
        cpx    = (cx > box.min_x) ? ((cx < box.max_x) ? cx : box.max_x) : box.min_x;
        cpy    = (cy > box.min_y) ? ((cy < box.max_y) ? cy : box.max_y) : box.min_y;
        if (in_box)
        begin
            px = near_x ? (left ? box.min_x : box.max_x) : cx;
            py = near_x ? cy : (bottom ? box.min_y : box.max_y);
        end
        else
        begin
            px = cpx;
            py = cpy;
        end
    end

    // stage 2
    logic                  v2_reg;
    side_t                 s2_reg;
    logic [DW-1:0]         adx, ady;
    logic                  far;

    always_comb
    begin
        adx = dx1_reg[DW-1] ? DW'(-dx1_reg) : DW'(dx1_reg);
        ady = dy1_reg[DW-1] ? DW'(-dy1_reg) : DW'(dy1_reg);
        far = (adx > {2'b00, r1_reg}) || (ady > {2'b00, r1_reg});
    end

    // stage 3
    logic                  v3_reg;
    side_t                 s3_reg;
    logic [2*RW-1:0]       sqx_reg, sqy_reg, r2_reg;

    // stage 4
    logic                  v4_reg;
    side_t                 s4_reg;
    side_t                 s4_next;
    logic [SQW-1:0]        d2_reg;
    logic [SQW-1:0]        d2_next;

    assign d2_next = SQW'(sqx_reg) + SQW'(sqy_reg);

    always_comb
    begin
        s4_next     = s3_reg;
        s4_next.hit = s3_reg.hit && (d2_next <= SQW'(r2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg  <= sext1(cx) - sext1(px);
            dy1_reg  <= sext1(cy) - sext1(py);
            cx1_reg  <= cx;
            cy1_reg  <= cy;
            r1_reg   <= item.circle_radius;
            ins1_reg <= in_box;

            s2_reg.cx     <= cx1_reg;
            s2_reg.cy     <= cy1_reg;
            s2_reg.r      <= r1_reg;
            s2_reg.ax     <= adx[RW-1:0];
            s2_reg.ay     <= ady[RW-1:0];
            s2_reg.neg_x  <= dx1_reg[DW-1];
            s2_reg.neg_y  <= dy1_reg[DW-1];
            s2_reg.in_box <= ins1_reg;
            s2_reg.hit    <= !far;

            s3_reg  <= s2_reg;
            sqx_reg <= s2_reg.ax * s2_reg.ax;
            sqy_reg <= s2_reg.ay * s2_reg.ay;
            r2_reg  <= s2_reg.r * s2_reg.r;

            s4_reg <= s4_next;
            d2_reg <= d2_next;
        end
    end

    assign out_valid = v4_reg;
    assign side      = s4_reg;
    assign d2        = d2_reg;

endmodule

>>> rtl/cbor_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on cbor_pkg.
`timescale 1ns / 1ps

module cbor_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  cbor_pkg::side_t           in_side,
    input  logic [cbor_pkg::SQW-1:0]  radicand,
    output logic                      out_valid,
    output cbor_pkg::side_t           out_side,
    output logic [cbor_pkg::RTW-1:0]  root
);
    import cbor_pkg::*;

    logic            v_reg    [RTW];
    side_t           s_reg    [RTW];
    logic [SQW-1:0]  rad_reg  [RTW];
    logic [RMW-1:0]  rem_reg  [RTW];
    logic [RTW-1:0]  root_reg [RTW];

    logic            v_s    [RTW+1];
    side_t           s_s    [RTW+1];
    logic [SQW-1:0]  rad_s  [RTW+1];
    logic [RMW-1:0]  rem_s  [RTW+1];
    logic [RTW-1:0]  root_s [RTW+1];

    assign v_s[0]    = in_valid;
    assign s_s[0]    = in_side;
    assign rad_s[0]  = radicand;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    for (genvar k = 0; k < RTW; k++)
    begin : g_stage
        logic [RMW-1:0] t_rem;
        logic [RMW-1:0] t_try;
        logic           take;

        assign t_rem = {rem_s[k][RMW-3:0], rad_s[k][SQW-1 -: 2]};
        assign t_try = {root_s[k], 2'b01};
        assign take  = t_rem >= t_try;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[k]    <= s_s[k];
                rad_reg[k]  <= rad_s[k] << 2;
                rem_reg[k]  <= take ? (t_rem - t_try) : t_rem;
                root_reg[k] <= {root_s[k][RTW-2:0], take};
            end
        end

        assign v_s[k+1]    = v_reg[k];
        assign s_s[k+1]    = s_reg[k];
        assign rad_s[k+1]  = rad_reg[k];
        assign rem_s[k+1]  = rem_reg[k];
        assign root_s[k+1] = root_reg[k];
    end

    assign out_valid = v_s[RTW];
    assign out_side  = s_s[RTW];
    assign root      = root_s[RTW];

endmodule

>>> rtl/cbor_div.sv
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
// Depends on cbor_pkg.
`timescale 1ns / 1ps

module cbor_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  cbor_pkg::dside_t         in_side,
    input  logic [cbor_pkg::NW-1:0]  num_x,
    input  logic [cbor_pkg::NW-1:0]  num_y,
    input  logic [cbor_pkg::RTW-1:0] den,
    output logic                     out_valid,
    output cbor_pkg::dside_t         out_side,
    output logic [cbor_pkg::QW-1:0]  quo_x,
    output logic [cbor_pkg::QW-1:0]  quo_y
);
    import cbor_pkg::*;

    logic            v_reg   [QW];
    dside_t          s_reg   [QW];
    logic [RTW-1:0]  d_reg   [QW];
    logic [QW-1:0]   nx_reg  [QW];
    logic [QW-1:0]   ny_reg  [QW];
    logic [RTW-1:0]  rx_reg  [QW];
    logic [RTW-1:0]  ry_reg  [QW];
    logic [QW-1:0]   qx_reg  [QW];
    logic [QW-1:0]   qy_reg  [QW];

    logic            v_s   [QW+1];
    dside_t          s_s   [QW+1];
    logic [RTW-1:0]  d_s   [QW+1];
    logic [QW-1:0]   nx_s  [QW+1];
    logic [QW-1:0]   ny_s  [QW+1];
    logic [RTW-1:0]  rx_s  [QW+1];
    logic [RTW-1:0]  ry_s  [QW+1];
    logic [QW-1:0]   qx_s  [QW+1];
    logic [QW-1:0]   qy_s  [QW+1];

    assign v_s[0]  = in_valid;
    assign s_s[0]  = in_side;
    assign d_s[0]  = den;
    assign nx_s[0] = num_x[QW-1:0];
    assign ny_s[0] = num_y[QW-1:0];
    assign rx_s[0] = RTW'(num_x[NW-1:QW]);
    assign ry_s[0] = RTW'(num_y[NW-1:QW]);
    assign qx_s[0] = '0;
    assign qy_s[0] = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RTW:0] tx, ty, dd;
        logic         gx, gy;

        assign tx = {rx_s[k], nx_s[k][QW-1]};
        assign ty = {ry_s[k], ny_s[k][QW-1]};
        assign dd = {1'b0, d_s[k]};
        assign gx = tx >= dd;
        assign gy = ty >= dd;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[k]  <= s_s[k];
                d_reg[k]  <= d_s[k];
                nx_reg[k] <= nx_s[k] << 1;
                ny_reg[k] <= ny_s[k] << 1;
                rx_reg[k] <= gx ? RTW'(tx - dd) : RTW'(tx);
                ry_reg[k] <= gy ? RTW'(ty - dd) : RTW'(ty);
                qx_reg[k] <= {qx_s[k][QW-2:0], gx};
                qy_reg[k] <= {qy_s[k][QW-2:0], gy};
            end
        end

        assign v_s[k+1]  = v_reg[k];
        assign s_s[k+1]  = s_reg[k];
        assign d_s[k+1]  = d_reg[k];
        assign nx_s[k+1] = nx_reg[k];
        assign ny_s[k+1] = ny_reg[k];
        assign rx_s[k+1] = rx_reg[k];
        assign ry_s[k+1] = ry_reg[k];
        assign qx_s[k+1] = qx_reg[k];
        assign qy_s[k+1] = qy_reg[k];
    end

    assign out_valid = v_s[QW];
    assign out_side  = s_s[QW];
    assign quo_x     = qx_s[QW];
    assign quo_y     = qy_s[QW];

endmodule

>>> rtl/circle_box_overlap_resolve_core.sv
// Top level of the circle/box overlap resolver: box registers, length and product
// stages, output register. Depends on cbor_pkg, cbor_geom, cbor_isqrt, cbor_div.
`timescale 1ns / 1ps

// One circle query is accepted per cycle unless stalled; its result passes through
// 4 geometry stages, 24 square-root stages, length and product stages, 24 divider
// stages, output register; the pipeline length is set by the one-bit-per-stage
// square root and divider. The whole pipeline holds while a result waits on
// result_ready. Box registers are written through the cfg channel, always ready.

module circle_box_overlap_resolve_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  cbor_pkg::item_t            item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output cbor_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cbor_pkg::CIW-1:0]   cfg_index,
    input  logic [cbor_pkg::CW-1:0]    cfg_data
);
    import cbor_pkg::*;

    box_t     box_reg;
    logic     adv;
    logic     out_valid_reg;
    result_t  out_reg;

    assign adv        = !out_valid_reg || result_ready;
    assign item_ready = adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_X: box_reg.min_x <= cfg_data;
                CFG_MIN_Y: box_reg.min_y <= cfg_data;
                CFG_MAX_X: box_reg.max_x <= cfg_data;
                CFG_MAX_Y: box_reg.max_y <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic             g_valid;
    side_t            g_side;
    logic [SQW-1:0]   g_d2;

    cbor_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .item      (item),
        .box       (box_reg),
        .out_valid (g_valid),
        .side      (g_side),
        .d2        (g_d2)
    );

    logic             q_valid;
    side_t            q_side;
    logic [RTW-1:0]   q_root;

    cbor_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (g_valid),
        .in_side   (g_side),
        .radicand  (g_d2),
        .out_valid (q_valid),
        .out_side  (q_side),
        .root      (q_root)
    );

    // length stage
    logic             l_valid_reg;
    dside_t           l_side_reg;
    logic [RTW-1:0]   l_root_reg;
    logic [CW-1:0]    l_len_reg;
    logic [RW-1:0]    l_ax_reg, l_ay_reg;
    logic [CW-1:0]    len_next;
    dside_t           ds_next;

    always_comb
    begin
        len_next      = q_side.in_box ? (CW'(q_side.r) + CW'(q_root))
                                      : (CW'(q_side.r) - CW'(q_root));
        ds_next.cx    = q_side.cx;
        ds_next.cy    = q_side.cy;
        ds_next.sub_x = q_side.neg_x ^ q_side.in_box;
        ds_next.sub_y = q_side.neg_y ^ q_side.in_box;
        ds_next.hit   = q_side.hit;
        ds_next.apply = q_side.hit && (q_root != '0);
    end

    // product stage
    logic             m_valid_reg;
    dside_t           m_side_reg;
    logic [RTW-1:0]   m_root_reg;
    logic [NW-1:0]    m_px_reg, m_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_valid_reg <= q_valid;
            m_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_side_reg <= ds_next;
            l_root_reg <= q_root;
            l_len_reg  <= len_next;
            l_ax_reg   <= q_side.ax;
            l_ay_reg   <= q_side.ay;

            m_side_reg <= l_side_reg;
            m_root_reg <= l_root_reg;
            m_px_reg   <= l_ax_reg * l_len_reg;
            m_py_reg   <= l_ay_reg * l_len_reg;
        end
    end

    logic             d_valid;
    dside_t           d_side;
    logic [QW-1:0]    d_qx, d_qy;

    cbor_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m_valid_reg),
        .in_side   (m_side_reg),
        .num_x     (m_px_reg),
        .num_y     (m_py_reg),
        .den       (m_root_reg),
        .out_valid (d_valid),
        .out_side  (d_side),
        .quo_x     (d_qx),
        .quo_y     (d_qy)
    );

    result_t  out_next;

    always_comb
    begin
        out_next.overlapped = d_side.hit;
        if (d_side.apply)
        begin
            out_next.resolved_x = sat_add(d_side.cx, d_qx, d_side.sub_x);
            out_next.resolved_y = sat_add(d_side.cy, d_qy, d_side.sub_y);
        end
        else
        begin
            out_next.resolved_x = d_side.cx;
            out_next.resolved_y = d_side.cy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled without output backpressure");

    a_apply_hit: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && d_side.apply |-> d_side.hit)
        else $error("displacement applied without overlap");

    a_nohit_same: assert property (@(posedge clk) disable iff (!rst_n)
        adv && d_valid && !d_side.hit |=> result.resolved_x == $past(d_side.cx))
        else $error("center moved without overlap");

endmodule
